@@ rtl/bpe_pkg.sv @@
// bpe_pkg: shared constants and types of the bernstein polynomial evaluator
// no dependencies; imported by every module in rtl/

package bpe_pkg;

	localparam int MAX_COEFFS_DEF = 16;

	// fixed-point format of t, u and h
	localparam int FRAC_W = 30;
	localparam logic [30:0] ONE_Q30  = 31'h4000_0000;
	localparam logic [63:0] HALF_Q30 = 64'h0000_0000_2000_0000;

	// numerator and denominator of the per-step ratio
	localparam int NUM_W = 64;
	localparam int DEN_W = 35;
	localparam int QUO_W = 31;

	// request codes
	localparam logic REQ_LOAD = 1'b0;
	localparam logic REQ_EVAL = 1'b1;

	// register map
	localparam logic REG_DEGREE = 1'b0;
	localparam logic [3:0] DEGREE_RST = 4'd3;

	typedef struct packed {
		logic             start;
		logic [NUM_W-1:0] num;
		logic [DEN_W-1:0] den;
	} div_req_t;

endpackage

@@ rtl/bpe_coef_store.sv @@
// bpe_coef_store: coefficient memory, one write port, one registered read port
// depends on bpe_pkg

module bpe_coef_store
	import bpe_pkg::*;
#(
	parameter int DEPTH = MAX_COEFFS_DEF,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic               clk,
	input  logic               we,
	input  logic [AW-1:0]      waddr,
	input  logic signed [31:0] wdata,
	input  logic [AW-1:0]      raddr,
	output logic signed [31:0] rdata
);

	logic signed [31:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

@@ rtl/bpe_divider.sv @@
// bpe_divider: restoring divider, one quotient bit per cycle
// depends on bpe_pkg; quotient known to fit in QUO_W bits, zero divisor gives 0

module bpe_divider
	import bpe_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  div_req_t         req,
	output logic             done,
	output logic [QUO_W-1:0] quot
);

	logic [DEN_W-1:0] rem_q;
	logic [QUO_W-1:0] lo_q;
	logic [DEN_W-1:0] den_q;
	logic [QUO_W-1:0] quot_q;
	logic [4:0]       cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [DEN_W:0] trial;
	logic           fits;

	assign trial = {rem_q, lo_q[QUO_W-1]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				if (req.den == '0) begin
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
					cnt_q  <= 5'(QUO_W);
				end
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			// upper part of the numerator is already below the divisor
			rem_q  <= DEN_W'(req.num[NUM_W-1:QUO_W]);
			lo_q   <= req.num[QUO_W-1:0];
			den_q  <= req.den;
			quot_q <= '0;
		end else if (busy_q) begin
			rem_q  <= fits ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
			lo_q   <= {lo_q[QUO_W-2:0], 1'b0};
			quot_q <= {quot_q[QUO_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

@@ rtl/bpe_seq.sv @@
// bpe_seq: step sequencer with the shared multiplier and the blend accumulator
// depends on bpe_pkg; drives bpe_divider and reads bpe_coef_store

module bpe_seq
	import bpe_pkg::*;
#(
	parameter int MAX_COEFFS = MAX_COEFFS_DEF,
	localparam int AW = $clog2(MAX_COEFFS)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               go,
	input  logic [30:0]        t_in,
	input  logic [3:0]         n_in,
	output logic               busy,
	output logic [AW-1:0]      rd_addr,
	input  logic signed [31:0] rd_data,
	output div_req_t           div_req,
	input  logic               div_done,
	input  logic [QUO_W-1:0]   div_quot,
	output logic               res_valid,
	output logic signed [31:0] res_value
);

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_RD0  = 4'd1;
	localparam logic [3:0] ST_C0   = 4'd2;
	localparam logic [3:0] ST_MP   = 4'd3;
	localparam logic [3:0] ST_PQ   = 4'd4;
	localparam logic [3:0] ST_MA   = 4'd5;
	localparam logic [3:0] ST_SD   = 4'd6;
	localparam logic [3:0] ST_SN   = 4'd7;
	localparam logic [3:0] ST_DIV  = 4'd8;
	localparam logic [3:0] ST_M1   = 4'd9;
	localparam logic [3:0] ST_M2   = 4'd10;
	localparam logic [3:0] ST_ACC  = 4'd11;

	logic [3:0] state_q;
	logic [3:0] k_q;
	logic [3:0] n_q;

	logic [30:0]        t_q;
	logic [30:0]        h_q;
	logic [30:0]        p_q;
	logic [33:0]        a_q;
	logic [33:0]        b_q;
	logic [34:0]        d_q;
	logic signed [31:0] acc_q;
	logic signed [63:0] s_q;
	logic signed [65:0] prod_q;
	logic signed [31:0] res_q;
	logic               res_valid_q;

	logic signed [32:0] mul_a;
	logic signed [32:0] mul_b;
	logic [30:0]        u;
	logic [4:0]         nk;
	logic signed [63:0] blend_sum;
	logic signed [31:0] acc_new;

	assign u  = ONE_Q30 - t_q;
	assign nk = 5'({1'b0, n_q} + 5'd1 - {1'b0, k_q});

	// shared multiplier operand selection
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_MP: begin
				mul_a = $signed({2'b00, h_q});
				mul_b = $signed({2'b00, t_q});
			end
			ST_PQ: begin
				mul_a = $signed({29'd0, k_q});
				mul_b = $signed({2'b00, u});
			end
			ST_MA: begin
				mul_a = $signed({2'b00, p_q});
				mul_b = $signed({28'd0, nk});
			end
			ST_M1: begin
				mul_a = 33'(acc_q);
				mul_b = $signed({2'b00, ONE_Q30 - div_quot});
			end
			ST_M2: begin
				mul_a = 33'(rd_data);
				mul_b = $signed({2'b00, h_q});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign blend_sum = s_q + prod_q[63:0] + $signed(HALF_Q30);
	assign acc_new   = blend_sum[61:30];

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		unique case (state_q)
			ST_IDLE: begin
				if (go) begin
					t_q <= t_in;
					h_q <= ONE_Q30;
				end
			end
			ST_C0:  acc_q <= rd_data;
			ST_PQ:  p_q <= 31'((prod_q[61:0] + 62'(HALF_Q30)) >> FRAC_W);
			ST_MA:  b_q <= prod_q[33:0];
			ST_SD: begin
				a_q <= prod_q[33:0];
				d_q <= {1'b0, prod_q[33:0]} + {1'b0, b_q};
			end
			ST_M1:  h_q <= div_quot;
			ST_M2:  s_q <= prod_q[63:0];
			ST_ACC: acc_q <= acc_new;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_C0) begin
			res_q <= rd_data;
		end else if (state_q == ST_ACC) begin
			res_q <= acc_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			k_q         <= '0;
			n_q         <= '0;
			res_valid_q <= 1'b0;
		end else begin
			res_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (go) begin
						k_q     <= '0;
						n_q     <= n_in;
						state_q <= ST_RD0;
					end
				end
				ST_RD0: state_q <= ST_C0;
				ST_C0: begin
					if (n_q == '0) begin
						res_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end else begin
						k_q     <= 4'd1;
						state_q <= ST_MP;
					end
				end
				ST_MP: state_q <= ST_PQ;
				ST_PQ: state_q <= ST_MA;
				ST_MA: state_q <= ST_SD;
				ST_SD: state_q <= ST_SN;
				ST_SN: state_q <= ST_DIV;
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_M1;
					end
				end
				ST_M1: state_q <= ST_M2;
				ST_M2: state_q <= ST_ACC;
				ST_ACC: begin
					if (k_q == n_q) begin
						res_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end else begin
						k_q     <= k_q + 4'd1;
						state_q <= ST_MP;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// rounded ratio numerator: A * 2^30 + D / 2
	assign div_req.start = (state_q == ST_SN);
	assign div_req.num   = {a_q, 30'd0} + NUM_W'(d_q[34:1]);
	assign div_req.den   = d_q;

	assign rd_addr   = AW'(k_q);
	assign busy      = (state_q != ST_IDLE);
	assign res_valid = res_valid_q;
	assign res_value = res_q;

endmodule

@@ rtl/bernstein_polynomial_eval.sv @@
// bernstein_polynomial_eval: top level, register port, coefficient store, sequencer
// depends on bpe_pkg, bpe_coef_store, bpe_divider, bpe_seq
//
// A load transaction (req_type 0) writes one Q16.16 coefficient; busy stays
// low. An evaluate transaction (req_type 1) takes t in Q2.30 (clamped to 0..1)
// and returns the polynomial value on curve_value with done high for exactly
// one cycle. n is the degree, at most MAX_COEFFS-1. Each degree step waits on
// the bit-serial divider for its 31 quotient bits and uses the shared
// multiplier and the adders. busy is high from the cycle after acceptance up
// to the done cycle, and the next transaction can be accepted in the done
// cycle. The receiver must take done/curve_value in that cycle: the result is
// not held. Every coefficient 0..n must have been loaded before an evaluate
// reads it.

module bernstein_polynomial_eval
	import bpe_pkg::*;
#(
	parameter int MAX_COEFFS = MAX_COEFFS_DEF,
	localparam int AW = $clog2(MAX_COEFFS)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               req_type,
	input  logic [3:0]         coef_index,
	input  logic signed [31:0] operand_value,
	output logic               done,
	output logic signed [31:0] curve_value,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	logic [3:0]         degree_q;
	logic               accept;
	logic               go;
	logic               store_we;
	logic [30:0]        t_sat;
	logic [3:0]         n_sat;
	logic [AW-1:0]      rd_addr;
	logic signed [31:0] rd_data;
	div_req_t           div_req;
	logic               div_done;
	logic [QUO_W-1:0]   div_quot;

	// register port
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			degree_q <= DEGREE_RST;
		end else if (psel && penable && pwrite && paddr[2] == REG_DEGREE) begin
			degree_q <= pwdata[3:0];
		end
	end

	assign prdata = (paddr[2] == REG_DEGREE) ? {28'd0, degree_q} : '0;

	assign accept   = start && !busy;
	assign go       = accept && req_type == REQ_EVAL;
	assign store_we = accept && req_type == REQ_LOAD && (32'(coef_index) < MAX_COEFFS);

	always_comb begin
		if (operand_value[31]) begin
			t_sat = '0;
		end else if (operand_value[30:0] > ONE_Q30) begin
			t_sat = ONE_Q30;
		end else begin
			t_sat = operand_value[30:0];
		end
	end

	assign n_sat = (32'(degree_q) > MAX_COEFFS - 1) ? 4'(MAX_COEFFS - 1) : degree_q;

	bpe_coef_store #(
		.DEPTH(MAX_COEFFS)
	) u_store (
		.clk  (clk),
		.we   (store_we),
		.waddr(AW'(coef_index)),
		.wdata(operand_value),
		.raddr(rd_addr),
		.rdata(rd_data)
	);

	bpe_divider u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (div_req),
		.done  (div_done),
		.quot  (div_quot)
	);

	bpe_seq #(
		.MAX_COEFFS(MAX_COEFFS)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (go),
		.t_in     (t_sat),
		.n_in     (n_sat),
		.busy     (busy),
		.rd_addr  (rd_addr),
		.rd_data  (rd_data),
		.div_req  (div_req),
		.div_done (div_done),
		.div_quot (div_quot),
		.res_valid(done),
		.res_value(curve_value)
	);

endmodule
